// ----- src/khrq_pkg.sv -----
// Package for the key hold and auto-repeat qualifier.
// Holds key codes, event codes, register indexes, state and result types.
// Used by khrq_eval and key_hold_repeat_qualifier_core.
package khrq_pkg;

  localparam int unsigned TickBits = 32;
  typedef logic [TickBits-1:0] tick_t;

  localparam logic [7:0] KeyNone  = 8'd0;
  localparam logic [7:0] KeyPower = 8'd1;
  localparam logic [7:0] KeyCw    = 8'd31;
  localparam logic [7:0] KeyCcw   = 8'd41;
  localparam logic [7:0] KeyPush  = 8'd51;

  typedef enum logic [1:0] {
    EvNone     = 2'd0,
    EvDispatch = 2'd1,
    EvPower    = 2'd2,
    EvUnlock   = 2'd3
  } event_kind_e;

  typedef enum logic [1:0] {
    RegRepeatInterval = 2'd0,
    RegPowerHold      = 2'd1,
    RegUnlockHold     = 2'd2,
    RegUnused         = 2'd3
  } reg_index_e;

  localparam logic [9:0]  RepeatIntervalReset = 10'd50;
  localparam logic [13:0] PowerHoldReset      = 14'd250;
  localparam logic [15:0] UnlockHoldReset     = 16'd3000;

  typedef struct packed {
    logic       pressed;
    logic [7:0] held_key;
    tick_t      time_mark;
    logic       power_fired;
  } khrq_state_t;

  typedef struct packed {
    logic [9:0]  repeat_interval;
    logic [13:0] power_hold;
    logic [15:0] unlock_hold;
  } khrq_cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] key_code;
    logic [31:0] now_ms;
    logic       lock_active;
    logic       lock_armed;
  } khrq_item_t;

  typedef struct packed {
    event_kind_e event_kind;
    logic [7:0]  event_key;
    logic        user_activity;
    logic        is_pressed;
  } khrq_result_t;

endpackage

// ----- src/khrq_eval.sv -----
// Combinational evaluation of one item against the press state.
// Produces the next press state and the result item.
// Depends on khrq_pkg.
module khrq_eval import khrq_pkg::*; (
  input  khrq_item_t   item_i,
  input  khrq_state_t  state_i,
  input  khrq_cfg_t    cfg_i,
  output khrq_state_t  state_o,
  output khrq_result_t result_o
);

  tick_t now;
  tick_t elapsed;
  logic  lock_ok;
  logic  repeat_due;
  logic  power_due;
  logic  unlock_due;

  assign now        = tick_t'(item_i.now_ms);
  assign elapsed    = now - state_i.time_mark;
  assign lock_ok    = item_i.lock_active & item_i.lock_armed;
  assign repeat_due = elapsed >= tick_t'(cfg_i.repeat_interval);
  assign power_due  = elapsed >= tick_t'(cfg_i.power_hold);
  assign unlock_due = elapsed >= tick_t'(cfg_i.unlock_hold);

  always_comb begin
    logic start;
    logic held_power;
    logic held_push;
    start      = 1'b0;
    held_power = state_i.pressed && (state_i.held_key == KeyPower) && !state_i.power_fired;
    held_push  = state_i.pressed && (state_i.held_key == KeyPush) && lock_ok;

    state_o                = state_i;
    result_o.event_kind    = EvNone;
    result_o.event_key     = KeyNone;
    result_o.user_activity = 1'b0;

    if (item_i.req_type) begin
      // Timed poll: only the hold timers of the held key are checked.
      if (held_power && power_due) begin
        state_o.time_mark   = now;
        state_o.power_fired = 1'b1;
        result_o.event_kind = EvPower;
        result_o.event_key  = KeyPower;
      end else if (held_push && unlock_due) begin
        state_o.time_mark   = now;
        result_o.event_kind = EvUnlock;
        result_o.event_key  = KeyPush;
      end
    end else begin
      result_o.user_activity = item_i.key_code != KeyNone;
      priority if (!state_i.pressed) begin
        start = item_i.key_code != KeyNone;
      end else if (item_i.key_code == KeyNone) begin
        state_o.pressed  = 1'b0;
        state_o.held_key = KeyNone;
      end else if (item_i.key_code == state_i.held_key) begin
        if (((item_i.key_code == KeyCw) || (item_i.key_code == KeyCcw)) && repeat_due) begin
          state_o.time_mark   = now;
          result_o.event_kind = EvDispatch;
          result_o.event_key  = item_i.key_code;
        end else if (held_power && power_due) begin
          state_o.time_mark   = now;
          state_o.power_fired = 1'b1;
          result_o.event_kind = EvPower;
          result_o.event_key  = KeyPower;
        end else if (held_push && unlock_due) begin
          state_o.time_mark   = now;
          result_o.event_kind = EvUnlock;
          result_o.event_key  = KeyPush;
        end
      end else begin
        start = 1'b1;
      end
    end

    // A new press; the power key is never dispatched but rearms its action.
    if (start) begin
      state_o.pressed   = 1'b1;
      state_o.held_key  = item_i.key_code;
      state_o.time_mark = now;
      if (item_i.key_code == KeyPower) begin
        state_o.power_fired = 1'b0;
      end else begin
        result_o.event_kind = EvDispatch;
        result_o.event_key  = item_i.key_code;
      end
    end

    result_o.is_pressed = state_o.pressed;
  end

endmodule

// ----- src/key_hold_repeat_qualifier_core.sv -----
// Top level of the key hold and auto-repeat qualifier.
// Holds the input stage, press state, configuration and result registers.
// Depends on khrq_pkg and khrq_eval.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries key samples or timed
//   polls with a millisecond tick and the child-lock flags. Every item gives
//   exactly one result on the output channel (out_valid_o / out_ready_i).
//   The configuration channel (cfg_valid_i / cfg_ready_o) writes the repeat
//   interval (index 0), power hold (index 1) and unlock hold (index 2); other
//   indexes are ignored. It is always ready.
//   The result is registered: an accepted item is captured in an input
//   register, and the press state is evaluated and updated as it moves into
//   the result register. One item is accepted every cycle while the
//   receiver takes results without stalling.
//   When the receiver stalls, the result holds and the input register keeps
//   one more item; in_ready_o drops only when both are full.
//   Reset clears the press state, both valid flags, and loads the register
//   defaults of 50, 250 and 3000 ms.
module key_hold_repeat_qualifier_core import khrq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  key_code_i,
  input  logic [31:0] now_ms_i,
  input  logic        lock_active_i,
  input  logic        lock_armed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_kind_o,
  output logic [7:0]  event_key_o,
  output logic        user_activity_o,
  output logic        is_pressed_o
);

  khrq_cfg_t    cfg_q;
  khrq_state_t  state_q, state_d;
  khrq_item_t   item_q;
  khrq_result_t result_q, result_d;
  logic         item_valid_q;
  logic         out_valid_q;
  logic         advance;
  logic         in_accept;

  assign cfg_ready_o = 1'b1;
  assign advance     = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !item_valid_q || advance;
  assign in_accept   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_interval <= RepeatIntervalReset;
      cfg_q.power_hold      <= PowerHoldReset;
      cfg_q.unlock_hold     <= UnlockHoldReset;
    end else if (cfg_valid_i) begin
      unique case (reg_index_e'(cfg_index_i))
        RegRepeatInterval: cfg_q.repeat_interval <= cfg_data_i[9:0];
        RegPowerHold:      cfg_q.power_hold      <= cfg_data_i[13:0];
        RegUnlockHold:     cfg_q.unlock_hold     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.req_type    <= req_type_i;
      item_q.key_code    <= key_code_i;
      item_q.now_ms      <= now_ms_i;
      item_q.lock_active <= lock_active_i;
      item_q.lock_armed  <= lock_armed_i;
    end
  end

  khrq_eval u_eval (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = result_q.event_kind;
  assign event_key_o     = result_q.event_key;
  assign user_activity_o = result_q.user_activity;
  assign is_pressed_o    = result_q.is_pressed;

`ifndef SYNTHESIS
  // An event without a kind never carries a key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (result_q.event_kind == EvNone) |-> result_q.event_key == KeyNone)
    else $error("event key set without an event");

  // A power action always belongs to the power key and leaves the key pressed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (result_q.event_kind == EvPower)
      |-> (result_q.event_key == KeyPower) && result_q.is_pressed)
    else $error("power action with wrong key or state");

  // Input backpressure only when both stages hold an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> item_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled while a stage is free");

  // The reported pressed flag matches the state left by the item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> result_q.is_pressed == state_q.pressed)
    else $error("reported pressed flag differs from state");
`endif

endmodule

// ----- sim/tb_top.sv -----
// Testbench for key_hold_repeat_qualifier_core: predicts one result per accepted item
// from its own copy of the press state and timing registers, checked in order.
// Depends on khrq_pkg and the core; driver, receiver and monitor are clocked processes.
`timescale 1ns / 1ps

module tb_top;
  import khrq_pkg::*;

  localparam int unsigned QuietLimit    = 3000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned ReportCap     = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [15:0] cfg_data_i = 16'd0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        req_type_i = 1'b0;
  logic [7:0]  key_code_i = 8'd0;
  logic [31:0] now_ms_i = 32'd0;
  logic        lock_active_i = 1'b0;
  logic        lock_armed_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  event_kind_o;
  logic [7:0]  event_key_o;
  logic        user_activity_o;
  logic        is_pressed_o;

  key_hold_repeat_qualifier_core DUT (.*);

  // Predicted press state and timing registers.
  logic        kp_pressed = 1'b0;
  logic [7:0]  kp_key = KeyNone;
  tick_t       kp_mark = '0;
  logic        kp_power_fired = 1'b0;
  logic [9:0]  hold_repeat = RepeatIntervalReset;
  logic [13:0] hold_power = PowerHoldReset;
  logic [15:0] hold_unlock = UnlockHoldReset;

  khrq_item_t   key_items[$];
  khrq_result_t pending_events[$];
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  send_gap = 0;
  int unsigned  recv_stall = 0;
  logic         in_taken = 1'b0;
  logic         sender_idles = 1'b1;
  logic         receiver_idles = 1'b1;
  logic         hold_off_req = 1'b0;
  logic         hold_off_started = 1'b0;
  tick_t        clock_ms = '0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic khrq_result_t qualify_key_item(khrq_item_t it);
    khrq_result_t r;
    tick_t        elapsed;
    logic         lock_ok;
    r.event_kind    = EvNone;
    r.event_key     = KeyNone;
    r.user_activity = 1'b0;
    elapsed = it.now_ms - kp_mark;
    lock_ok = it.lock_active & it.lock_armed;
    if (it.req_type) begin
      // A poll only looks at the power and unlock hold timers.
      if (kp_pressed && kp_key == KeyPower && !kp_power_fired && elapsed >= hold_power) begin
        kp_mark = it.now_ms;
        kp_power_fired = 1'b1;
        r.event_kind = EvPower;
        r.event_key = KeyPower;
      end else if (kp_pressed && kp_key == KeyPush && lock_ok && elapsed >= hold_unlock) begin
        kp_mark = it.now_ms;
        r.event_kind = EvUnlock;
        r.event_key = KeyPush;
      end
    end else begin
      r.user_activity = (it.key_code != KeyNone);
      if (!kp_pressed || (it.key_code != KeyNone && it.key_code != kp_key)) begin
        if (it.key_code != KeyNone) begin
          kp_key = it.key_code;
          kp_mark = it.now_ms;
          kp_pressed = 1'b1;
          if (it.key_code == KeyPower) begin
            kp_power_fired = 1'b0;
          end else begin
            r.event_kind = EvDispatch;
            r.event_key = it.key_code;
          end
        end
      end else if (it.key_code == KeyNone) begin
        kp_pressed = 1'b0;
        kp_key = KeyNone;
      end else if ((it.key_code == KeyCw || it.key_code == KeyCcw) && elapsed >= hold_repeat) begin
        kp_mark = it.now_ms;
        r.event_kind = EvDispatch;
        r.event_key = it.key_code;
      end else if (it.key_code == KeyPower && !kp_power_fired && elapsed >= hold_power) begin
        kp_mark = it.now_ms;
        kp_power_fired = 1'b1;
        r.event_kind = EvPower;
        r.event_key = KeyPower;
      end else if (it.key_code == KeyPush && lock_ok && elapsed >= hold_unlock) begin
        kp_mark = it.now_ms;
        r.event_kind = EvUnlock;
        r.event_key = KeyPush;
      end
    end
    r.is_pressed = kp_pressed;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= ReportCap)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    khrq_item_t   item;
    khrq_result_t want;
    logic         moved;
    in_taken = 1'b0;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        case (reg_index_e'(cfg_index_i))
          RegRepeatInterval: hold_repeat = cfg_data_i[9:0];
          RegPowerHold:      hold_power = cfg_data_i[13:0];
          RegUnlockHold:     hold_unlock = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        item.req_type    = req_type_i;
        item.key_code    = key_code_i;
        item.now_ms      = now_ms_i;
        item.lock_active = lock_active_i;
        item.lock_armed  = lock_armed_i;
        pending_events.push_back(qualify_key_item(item));
        in_taken = 1'b1;
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (pending_events.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportCap)
            $display("%0t: result with no item waiting, expected none, actual kind %0d key %0d",
                     $time, event_kind_o, event_key_o);
        end else begin
          want = pending_events.pop_front();
          check_field("event_kind", want.event_kind, event_kind_o);
          check_field("event_key", want.event_key, event_key_o);
          check_field("user_activity", want.user_activity, user_activity_o);
          check_field("is_pressed", want.is_pressed, is_pressed_o);
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin : driver
    khrq_item_t nxt;
    logic       drive_valid;
    drive_valid = in_valid_i;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      drive_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (key_items.size() > 0) begin
        nxt = key_items.pop_front();
        drive_valid = 1'b1;
        req_type_i    <= nxt.req_type;
        key_code_i    <= nxt.key_code;
        now_ms_i      <= nxt.now_ms;
        lock_active_i <= nxt.lock_active;
        lock_armed_i  <= nxt.lock_armed;
        send_gap = sender_idles ? idle_gap() : 0;
      end
    end
    in_valid_i <= drive_valid;
  end

  always @(negedge clk_i) begin : receiver
    if (hold_off_req && !hold_off_started) begin
      hold_off_started = 1'b1;
      recv_stall = HoldOffCycles;
    end
    if (recv_stall > 0) begin
      recv_stall--;
      out_ready_i <= 1'b0;
    end else if (receiver_idles && $urandom_range(99) < 25) begin
      recv_stall = idle_gap();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic queue_item(logic rt, logic [7:0] key, tick_t now, logic la, logic lr);
    khrq_item_t it;
    it.req_type    = rt;
    it.key_code    = key;
    it.now_ms      = now;
    it.lock_active = la;
    it.lock_armed  = lr;
    key_items.push_back(it);
  endtask

  // A press, a few holds or polls around the relevant hold time, then mostly a release.
  task automatic queue_press_sequence();
    logic [7:0]  key;
    logic [1:0]  locks;
    int unsigned hold_ms;
    int unsigned delta;
    int unsigned steps;
    case ($urandom_range(5))
      0:       key = KeyPower;
      1:       key = KeyCw;
      2:       key = KeyCcw;
      3, 4:    key = KeyPush;
      default: key = 8'($urandom_range(255, 2));
    endcase
    locks = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'b11;
    queue_item(1'b0, key, clock_ms, locks[1], locks[0]);
    steps = $urandom_range(6, 1);
    repeat (steps) begin
      if (key == KeyPower) hold_ms = hold_power;
      else if (key == KeyPush) hold_ms = hold_unlock;
      else if (key == KeyCw || key == KeyCcw) hold_ms = hold_repeat;
      else hold_ms = 50;
      case ($urandom_range(3))
        0:       delta = (hold_ms > 0) ? hold_ms - 1 : 0;
        1:       delta = hold_ms;
        default: delta = $urandom_range(2 * hold_ms + 2);
      endcase
      clock_ms += delta;
      if ($urandom_range(7) == 0) locks = 2'($urandom_range(3));
      if ($urandom_range(2) == 0) begin
        queue_item(1'b1, 8'($urandom_range(255)), clock_ms, locks[1], locks[0]);
      end else begin
        if ($urandom_range(9) == 0) key = 8'($urandom_range(255, 1));
        queue_item(1'b0, key, clock_ms, locks[1], locks[0]);
      end
    end
    if ($urandom_range(4) != 0) begin
      clock_ms += $urandom_range(20);
      queue_item(1'b0, KeyNone, clock_ms, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic run_phase(int unsigned n_items, logic snd_idle, logic rcv_idle);
    int unsigned target;
    sender_idles = snd_idle;
    receiver_idles = rcv_idle;
    // Half of the phases start close to the top of the tick so that it wraps.
    if ($urandom_range(1) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(20000);
    else clock_ms = $urandom();
    target = key_items.size() + n_items;
    while (key_items.size() < target) begin
      if ($urandom_range(4) == 0)
        queue_item(1'($urandom_range(1)), 8'($urandom_range(255)), $urandom(),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
      else
        queue_press_sequence();
    end
    while (key_items.size() != 0 || in_valid_i || pending_events.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_index_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_timing(logic [15:0] rep, logic [15:0] pow, logic [15:0] unl);
    write_reg(RegRepeatInterval, rep);
    write_reg(RegPowerHold, pow);
    write_reg(RegUnlockHold, unl);
    write_reg(RegUnused, 16'($urandom()));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed items with the reset timing: 50 ms repeat, 250 ms power, 3000 ms unlock.
    queue_item(1'b0, KeyNone, 32'd10, 1'b1, 1'b1);
    queue_item(1'b1, KeyNone, 32'd20, 1'b1, 1'b1);
    queue_item(1'b0, KeyCw, 32'd1000, 1'b0, 1'b0);
    queue_item(1'b0, KeyCw, 32'd1049, 1'b0, 1'b0);
    queue_item(1'b0, KeyCw, 32'd1099, 1'b0, 1'b0);
    queue_item(1'b0, KeyCcw, 32'd1100, 1'b0, 1'b0);
    queue_item(1'b0, KeyNone, 32'd1110, 1'b0, 1'b0);
    queue_item(1'b0, KeyPower, 32'd2000, 1'b0, 1'b0);
    queue_item(1'b1, KeyNone, 32'd2249, 1'b0, 1'b0);
    queue_item(1'b1, KeyNone, 32'd2250, 1'b0, 1'b0);
    queue_item(1'b0, KeyPower, 32'd3000, 1'b0, 1'b0);
    queue_item(1'b0, KeyNone, 32'd3010, 1'b0, 1'b0);
    // Power press just below the tick wrap; the hold completes after it.
    queue_item(1'b0, KeyPower, 32'hFFFF_FF80, 1'b0, 1'b0);
    queue_item(1'b0, KeyPower, 32'h0000_007A, 1'b0, 1'b0);
    queue_item(1'b0, KeyPush, 32'd100, 1'b1, 1'b1);
    queue_item(1'b1, KeyNone, 32'd3099, 1'b1, 1'b1);
    queue_item(1'b1, KeyNone, 32'd3100, 1'b1, 1'b0);
    queue_item(1'b1, KeyNone, 32'd3100, 1'b1, 1'b1);
    queue_item(1'b0, KeyPush, 32'd6100, 1'b1, 1'b1);
    queue_item(1'b0, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    queue_item(1'b0, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
    queue_item(1'b1, 8'hAA, 32'h5555_5555, 1'b1, 1'b1);
    queue_item(1'b0, KeyNone, 32'hAAAA_AAAA, 1'b1, 1'b1);
    queue_item(1'b0, 8'd128, 32'd0, 1'b0, 1'b1);
    queue_item(1'b0, KeyNone, 32'd5, 1'b1, 1'b0);
    run_phase(80, 1'b1, 1'b1);

    set_timing(16'd1, 16'd1, 16'd1);
    run_phase(80, 1'b1, 1'b1);

    // The receiver holds off for a long stretch while items keep coming.
    set_timing(16'd1000, 16'd10000, 16'd60000);
    hold_off_req = 1'b1;
    run_phase(80, 1'b0, 1'b1);

    // Zero hold times are met on every item; no idling on either side.
    set_timing(16'd0, 16'd0, 16'd0);
    run_phase(80, 1'b0, 1'b0);

    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(80, 1'b1, 1'b1);

    set_timing(16'($urandom_range(1000, 1)), 16'($urandom_range(10000, 1)),
               16'($urandom_range(60000, 1)));
    run_phase(80, 1'b1, 1'b1);

    repeat (6) @(posedge clk_i);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
